// ----- hw/rtl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, codes and widths of the monomial block encoder.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int MAX_VARS_DEF   = 32;
  localparam int MAX_BLOCKS_DEF = 8;
  localparam int RESULT_LIMIT   = 40;

  localparam int WORD_W  = 32;
  localparam int FILL_W  = 6;   // holds 0..32
  localparam int SIZE_W  = 6;
  localparam int ADDR_W  = 10;  // slot/exponent position of a run
  localparam int WADDR_W = 8;
  localparam int WBLK_W  = 3;
  localparam int WPOS_W  = 5;
  localparam int BCNT_W  = 4;
  localparam int RES_W   = 6;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_DESC   = 2'd1;
  localparam logic [1:0] KIND_WEIGHT = 2'd2;

  localparam logic [2:0] BK_LEX     = 3'd0;
  localparam logic [2:0] BK_REVLEX  = 3'd1;
  localparam logic [2:0] BK_GREV    = 3'd2;
  localparam logic [2:0] BK_GREV2   = 3'd3;
  localparam logic [2:0] BK_GREV4   = 3'd4;
  localparam logic [2:0] BK_LEX2    = 3'd5;
  localparam logic [2:0] BK_LEX4    = 3'd6;
  localparam logic [2:0] BK_WEIGHTS = 3'd7;

  localparam logic CFG_BLOCK_COUNT = 1'b0;
  localparam logic CFG_DIRECTION   = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [7:0]         index;
    logic [2:0]         block_kind;
    logic [5:0]         block_size;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] word;
    logic               is_last;
  } out_rsp_t;

  typedef struct packed {
    logic push;
    logic fin;
  } rq_ctl_t;

  typedef enum logic [1:0] {PK_ONE, PK_TWO, PK_FOUR} pack_t;

  typedef enum logic [2:0] {
    S_IDLE, S_BLK, S_ISSUE, S_PROC, S_WMUL, S_WACC, S_WEMIT, S_FIN
  } seq_state_t;

  function automatic pack_t pack_of(input logic [2:0] kd);
    pack_t p;
    case (kd)
      BK_GREV2, BK_LEX2: p = PK_TWO;
      BK_GREV4, BK_LEX4: p = PK_FOUR;
      default:           p = PK_ONE;
    endcase
    return p;
  endfunction

  function automatic logic is_grev(input logic [2:0] kd);
    return (kd == BK_GREV) || (kd == BK_GREV2) || (kd == BK_GREV4);
  endfunction

endpackage

// ----- hw/rtl/mbe_value_buf.sv -----
// ----------------------------------------------------------------------------
// mbe_value_buf
// Vector buffer: one write and one registered read port, positions at or
// past the fill count read as zero.
// ----------------------------------------------------------------------------
module mbe_value_buf
  import mbe_pkg::*;
#(
  parameter int MAX_VARS = MAX_VARS_DEF
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [((MAX_VARS > 1) ? $clog2(MAX_VARS) : 1)-1:0] waddr,
  input  logic [WORD_W-1:0]         wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  input  logic [FILL_W-1:0]         fill,
  output logic [WORD_W-1:0]         rdata
);
  localparam int AW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

  logic [WORD_W-1:0] mem [MAX_VARS];
  logic [WORD_W-1:0] raw;
  logic              hit;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      raw <= mem[raddr[AW-1:0]];
      hit <= raddr < {{(ADDR_W-FILL_W){1'b0}}, fill};
    end
  end

  assign rdata = hit ? raw : '0;
endmodule

// ----- hw/rtl/mbe_weight_mem.sv -----
// ----------------------------------------------------------------------------
// mbe_weight_mem
// Weight store, 256 words, one write and one registered read port.
// ----------------------------------------------------------------------------
module mbe_weight_mem
  import mbe_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [WADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0]  wdata,
  input  logic               re,
  input  logic [WADDR_W-1:0] raddr,
  output logic [WORD_W-1:0]  rdata
);
  logic [WORD_W-1:0] mem [2**WADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- hw/rtl/mbe_result_queue.sv -----
// ----------------------------------------------------------------------------
// mbe_result_queue
// Holds one result back so the final one of a run can be marked, then
// drives the output register.
// ----------------------------------------------------------------------------
module mbe_result_queue
  import mbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  rq_ctl_t           ctl,
  input  logic [WORD_W-1:0] word,
  output logic              ready,
  output logic              dst_valid,
  input  logic              dst_stall,
  output out_rsp_t          dst_data
);
  logic              pend_valid;
  logic [WORD_W-1:0] pend_word;
  logic              out_valid;
  logic              out_free;
  logic              move;

  assign out_free  = !out_valid || !dst_stall;
  assign ready     = !pend_valid || out_free;
  assign move      = pend_valid && ready && (ctl.push || ctl.fin);
  assign dst_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !dst_stall) begin
        out_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end
      if (ctl.push && ready) begin
        pend_valid <= 1'b1;
      end else if (ctl.fin && ready) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && ready) begin
      pend_word <= word;
    end
    if (move) begin
      dst_data.word    <= pend_word;
      dst_data.is_last <= ctl.fin;
    end
  end
endmodule

// ----- hw/rtl/mbe_walker.sv -----
// ----------------------------------------------------------------------------
// mbe_walker
// Takes requests, keeps the block table and walks the buffer block by
// block, one position per read, producing slot words, exponents or weighted sums.
// ----------------------------------------------------------------------------
module mbe_walker
  import mbe_pkg::*;
#(
  parameter int MAX_VARS   = MAX_VARS_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  in_req_t             src_data,
  input  logic [BCNT_W-1:0]   block_count,
  input  logic                direction,
  output logic                buf_we,
  output logic [((MAX_VARS > 1) ? $clog2(MAX_VARS) : 1)-1:0] buf_waddr,
  output logic                buf_re,
  output logic [ADDR_W-1:0]   buf_raddr,
  output logic [FILL_W-1:0]   fill,
  input  logic [WORD_W-1:0]   buf_rdata,
  output logic                w_we,
  output logic                w_re,
  output logic [WADDR_W-1:0]  w_raddr,
  input  logic [WORD_W-1:0]   w_rdata,
  input  logic                rq_ready,
  output rq_ctl_t             rq_ctl,
  output logic [WORD_W-1:0]   rq_word
);
  localparam int AW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  seq_state_t state, state_next;

  logic [2:0]        kt [MAX_BLOCKS];
  logic [SIZE_W-1:0] st [MAX_BLOCKS];

  logic [BCNT_W-1:0] b, nb;
  logic [2:0]        kd;
  logic [SIZE_W-1:0] n, cnt;
  pack_t             pk;
  logic              grev, phase;
  logic [ADDR_W-1:0] base;
  logic [WORD_W-1:0] total, cur, prev, pack, wsum;
  logic signed [63:0] prod;
  logic [RES_W-1:0]  res_cnt;

  logic              accept;
  logic [2:0]        d_kd;
  logic [SIZE_W-1:0] d_bs, d_n;
  logic [SIZE_W-1:0] k, n_m1;
  logic [ADDR_W-1:0] k_word, words, addr;
  logic [1:0]        q;
  logic [WORD_W-1:0] x, tval, field, packed_w, f, enc_word, dec_word;
  logic              is_end, group_done, want_push;
  logic [65:0]       acc;
  logic [WORD_W-1:0] acc_q;
  logic              acc_rnd;

  assign accept    = src_valid && (state == S_IDLE);
  assign src_stall = (state != S_IDLE);

  assign buf_we    = accept && (src_data.kind == KIND_DATA) && (fill < FILL_W'(MAX_VARS));
  assign buf_waddr = fill[AW-1:0];
  assign w_we      = accept && (src_data.kind == KIND_WEIGHT);

  // descriptor of the block about to start
  assign d_kd = kt[b[BW-1:0]];
  assign d_bs = st[b[BW-1:0]];
  assign d_n  = (d_bs > SIZE_W'(MAX_VARS)) ? SIZE_W'(MAX_VARS) : d_bs;

  assign n_m1   = n - 1'b1;
  assign k      = (direction && grev) ? (n_m1 - cnt) : cnt;
  assign is_end = (cnt == n_m1);

  always_comb begin
    case (pk)
      PK_TWO:  k_word = {{(ADDR_W-SIZE_W){1'b0}}, 1'b0, k[SIZE_W-1:1]};
      PK_FOUR: k_word = {{(ADDR_W-SIZE_W){1'b0}}, 2'b00, k[SIZE_W-1:2]};
      default: k_word = {{(ADDR_W-SIZE_W){1'b0}}, k};
    endcase
  end

  always_comb begin
    if (kd == BK_WEIGHTS) begin
      addr = {{(ADDR_W-SIZE_W){1'b0}}, cnt};
    end else if (direction) begin
      addr = base + k_word;
    end else if (grev && phase) begin
      // second pass runs backward: t[j] = t[j-1] - v[n-j]
      addr = base + {{(ADDR_W-SIZE_W){1'b0}}, n} - {{(ADDR_W-SIZE_W){1'b0}}, cnt};
    end else begin
      addr = base + {{(ADDR_W-SIZE_W){1'b0}}, cnt};
    end
  end

  assign buf_re    = (state == S_ISSUE);
  assign buf_raddr = addr;
  assign w_re      = (state == S_ISSUE);
  assign w_raddr   = {b[WBLK_W-1:0], cnt[WPOS_W-1:0]};

  assign x = buf_rdata;

  always_comb begin
    case (pk)
      PK_TWO:  q = {1'b0, (direction ? k[0] : cnt[0])};
      PK_FOUR: q = direction ? k[1:0] : cnt[1:0];
      default: q = 2'd0;
    endcase
  end

  // encode: value of this slot and its place in the packed word
  assign tval = (grev && phase) ? ((cnt == '0) ? total : cur - x) : x;

  always_comb begin
    case (pk)
      PK_TWO:  field = q[0] ? {16'h0, tval[15:0]} : {tval[15:0], 16'h0};
      PK_FOUR: begin
        case (q)
          2'd0:    field = {tval[7:0], 24'h0};
          2'd1:    field = {8'h0, tval[7:0], 16'h0};
          2'd2:    field = {16'h0, tval[7:0], 8'h0};
          default: field = {24'h0, tval[7:0]};
        endcase
      end
      default: field = tval;
    endcase
  end

  assign packed_w = ((q == 2'd0) ? '0 : pack) | field;

  always_comb begin
    case (pk)
      PK_TWO:  group_done = is_end || (q == 2'd1);
      PK_FOUR: group_done = is_end || (q == 2'd3);
      default: group_done = 1'b1;
    endcase
  end

  assign enc_word = (pk != PK_ONE) ? packed_w :
                    ((kd == BK_REVLEX) ? (32'd0 - tval) : tval);

  // decode: field of the slot word, zero-extended
  always_comb begin
    case (pk)
      PK_TWO:  f = q[0] ? {16'h0, x[15:0]} : {16'h0, x[31:16]};
      PK_FOUR: begin
        case (q)
          2'd0:    f = {24'h0, x[31:24]};
          2'd1:    f = {24'h0, x[23:16]};
          2'd2:    f = {24'h0, x[15:8]};
          default: f = {24'h0, x[7:0]};
        endcase
      end
      default: f = x;
    endcase
  end

  assign dec_word = grev ? ((cnt == '0) ? f : f - prev) :
                    ((kd == BK_REVLEX) ? (32'd0 - f) : f);

  always_comb begin
    case (pk)
      PK_TWO:  words = ({{(ADDR_W-SIZE_W){1'b0}}, n} + 1'b1) >> 1;
      PK_FOUR: words = ({{(ADDR_W-SIZE_W){1'b0}}, n} + 2'd3) >> 2;
      default: words = {{(ADDR_W-SIZE_W){1'b0}}, n};
    endcase
  end

  // weight step, truncated toward zero
  assign acc     = {{18{wsum[31]}}, wsum, 16'h0} + {{2{prod[63]}}, prod};
  assign acc_rnd = acc[65] && (acc[15:0] != '0);
  assign acc_q   = acc[47:16] + {31'h0, acc_rnd};

  assign want_push = (state == S_WEMIT) ||
                     ((state == S_PROC) && (direction || ((!grev || phase) && group_done)));
  assign rq_word   = (state == S_WEMIT) ? wsum : (direction ? dec_word : enc_word);

  always_comb begin
    state_next  = state;
    rq_ctl.push = want_push && rq_ready && (res_cnt < RES_W'(RESULT_LIMIT));
    rq_ctl.fin  = (state == S_FIN);
    case (state)
      S_IDLE: begin
        if (accept && (src_data.kind == KIND_DATA) && src_data.last) begin
          state_next = S_BLK;
        end
      end
      S_BLK: begin
        if (b >= nb) begin
          state_next = S_FIN;
        end else if (d_kd == BK_WEIGHTS) begin
          if (!direction) begin
            state_next = (d_n == '0) ? S_WEMIT : S_ISSUE;
          end
        end else if (d_n != '0) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: state_next = (kd == BK_WEIGHTS) ? S_WMUL : S_PROC;
      S_PROC: begin
        if (rq_ready) begin
          state_next = (is_end && (direction || !grev || phase)) ? S_BLK : S_ISSUE;
        end
      end
      S_WMUL:  state_next = S_WACC;
      S_WACC:  state_next = is_end ? S_WEMIT : S_ISSUE;
      S_WEMIT: state_next = rq_ready ? S_BLK : S_WEMIT;
      S_FIN:   state_next = rq_ready ? S_IDLE : S_FIN;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      res_cnt <= '0;
    end else begin
      if (buf_we) begin
        fill <= fill + 1'b1;
      end
      if (state == S_FIN && rq_ready) begin
        fill <= '0;
      end
      if (state == S_IDLE) begin
        res_cnt <= '0;
      end else if (rq_ctl.push) begin
        res_cnt <= res_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (src_data.kind == KIND_DESC) &&
        (src_data.index < WADDR_W'(MAX_BLOCKS))) begin
      kt[src_data.index[BW-1:0]] <= src_data.block_kind;
      st[src_data.index[BW-1:0]] <= src_data.block_size;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        b    <= '0;
        base <= '0;
        nb   <= (block_count > BCNT_W'(MAX_BLOCKS)) ? BCNT_W'(MAX_BLOCKS) : block_count;
      end
      S_BLK: begin
        kd    <= d_kd;
        n     <= d_n;
        pk    <= pack_of(d_kd);
        grev  <= is_grev(d_kd);
        phase <= 1'b0;
        cnt   <= '0;
        total <= '0;
        wsum  <= '0;
        if (b < nb) begin
          if (d_kd == BK_WEIGHTS && direction) begin
            base <= base + 1'b1;
            b    <= b + 1'b1;
          end else if (d_kd != BK_WEIGHTS && d_n == '0) begin
            b <= b + 1'b1;
          end
        end
      end
      S_PROC: begin
        if (rq_ready) begin
          pack <= packed_w;
          prev <= f;
          cur  <= tval;
          if (grev && !phase && !direction) begin
            total <= total + x;
          end
          if (is_end) begin
            if (grev && !phase && !direction) begin
              phase <= 1'b1;
              cnt   <= '0;
            end else begin
              b    <= b + 1'b1;
              base <= base + (direction ? words : {{(ADDR_W-SIZE_W){1'b0}}, n});
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
      end
      S_WMUL: prod <= $signed(w_rdata) * $signed(buf_rdata);
      S_WACC: begin
        wsum <= acc_q;
        if (!is_end) begin
          cnt <= cnt + 1'b1;
        end
      end
      S_WEMIT: begin
        if (rq_ready) begin
          b <= b + 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(MAX_VARS)) else $error("fill count past buffer depth");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RES_W'(RESULT_LIMIT)) else $error("result count past limit");

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && rq_ready) |=> (fill == '0 && state == S_IDLE))
    else $error("run end did not clear the buffer");

  a_cnt_in_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROC || state == S_WACC) |-> (cnt < n))
    else $error("position counter left the block");
endmodule

// ----- hw/rtl/monomial_block_encoder.sv -----
// Requests are taken only while no walk runs, one walk at a time. After the
// last data request the walk takes each block in turn and reads each position;
// a weight block multiplies and accumulates, then emits the sum, and the
// buffer port sees each position of an encoded grevlex block twice. Then the
// run closes. The walk pauses while two results are held and the output
// stalls. Reset: block_count=1, direction=0.
// ----------------------------------------------------------------------------
// monomial_block_encoder
// Encodes a monomial exponent vector into block-ordered slot words, or back.
// ----------------------------------------------------------------------------
module monomial_block_encoder
  import mbe_pkg::*;
#(
  parameter int MAX_VARS   = MAX_VARS_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  in_req_t     src_data,
  output logic        dst_valid,
  input  logic        dst_stall,
  output out_rsp_t    dst_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);
  localparam int AW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

  logic [BCNT_W-1:0]  block_count;
  logic               direction;
  logic               buf_we, buf_re, w_we, w_re, rq_ready;
  logic [AW-1:0]      buf_waddr;
  logic [ADDR_W-1:0]  buf_raddr;
  logic [FILL_W-1:0]  fill;
  logic [WORD_W-1:0]  buf_rdata, w_rdata, rq_word;
  logic [WADDR_W-1:0] w_raddr;
  rq_ctl_t            rq_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BCNT_W'(1);
      direction   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLOCK_COUNT: block_count <= cfg_data;
        CFG_DIRECTION:   direction   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mbe_value_buf #(.MAX_VARS(MAX_VARS)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (src_data.value),
    .re    (buf_re),
    .raddr (buf_raddr),
    .fill  (fill),
    .rdata (buf_rdata)
  );

  mbe_weight_mem u_wmem (
    .clk   (clk),
    .we    (w_we),
    .waddr (src_data.index),
    .wdata (src_data.value),
    .re    (w_re),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  mbe_walker #(.MAX_VARS(MAX_VARS), .MAX_BLOCKS(MAX_BLOCKS)) u_walk (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_stall   (src_stall),
    .src_data    (src_data),
    .block_count (block_count),
    .direction   (direction),
    .buf_we      (buf_we),
    .buf_waddr   (buf_waddr),
    .buf_re      (buf_re),
    .buf_raddr   (buf_raddr),
    .fill        (fill),
    .buf_rdata   (buf_rdata),
    .w_we        (w_we),
    .w_re        (w_re),
    .w_raddr     (w_raddr),
    .w_rdata     (w_rdata),
    .rq_ready    (rq_ready),
    .rq_ctl      (rq_ctl),
    .rq_word     (rq_word)
  );

  mbe_result_queue u_rq (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rq_ctl),
    .word      (rq_word),
    .ready     (rq_ready),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );
endmodule
